/* sv/fik_pkg.sv */
package fik_pkg;

  localparam int CFG_AW = 3;

  localparam logic [CFG_AW-1:0] CFG_BASE_X    = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_BASE_Y    = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_BASE_Z    = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_MAX_ITER  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_TOLERANCE = 3'd4;

  localparam int ITER_W = 4;
  localparam int TOL_W  = 16;

  localparam logic [ITER_W-1:0] MAX_ITER_RST = 4'd10;
  localparam logic [TOL_W-1:0]  TOL_RST      = 16'd655;

  // Solver program steps.
  typedef enum logic [3:0] {
    STP_SEG0,
    STP_SEG1,
    STP_FAR,
    STP_FAR_J1,
    STP_FAR_J2,
    STP_F12,
    STP_F01,
    STP_B10,
    STP_B21,
    STP_TOL
  } step_t;

  typedef struct packed {
    logic start;
    logic op_div;
  } ar_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ar_stat_t;

  function automatic longint sat_coord(input longint v, input int cbits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (cbits - 1)) - 1;
    lo = -(longint'(1) <<< (cbits - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

endpackage

/* sv/fik_arith.sv */
module fik_arith import fik_pkg::*; #(
  parameter int SQ_IN   = 50,
  parameter int DIV_NUM = 40,
  parameter int DIV_Q   = 17,
  parameter int DEN_W   = 25,
  parameter int RES_W   = 26
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ar_ctl_t            ctl,
  input  logic [SQ_IN-1:0]   radicand,
  input  logic [DIV_NUM-1:0] num,
  input  logic [DEN_W-1:0]   den,
  output logic [RES_W-1:0]   result,
  output ar_stat_t           stat
);

  localparam int SO   = SQ_IN / 2;
  localparam int SRCW = (SQ_IN > DIV_NUM) ? SQ_IN : DIV_NUM;
  localparam int RW   = ((SO + 2) > (DEN_W + 1)) ? (SO + 2) : (DEN_W + 1);
  localparam int NSTP = (SO > DIV_Q) ? SO : DIV_Q;
  localparam int CW   = $clog2(NSTP + 1);

  logic [SRCW-1:0]  src_r;
  logic [RW-1:0]    rem_r;
  logic [RES_W-1:0] acc_r;
  logic [CW-1:0]    cnt_r;
  logic             div_r;
  logic             busy_r;
  logic             done_r;

  logic [RW+1:0] sh_c;
  logic [RW+1:0] trial_c;
  logic [RW+1:0] diff_c;
  logic          ge_c;

  // One shared compare/subtract serves both the root digit and the quotient bit.
  always_comb begin
    if (div_r) begin
      sh_c    = {1'b0, rem_r, src_r[SRCW-1]};
      trial_c = (RW+2)'(den);
    end else begin
      sh_c    = {rem_r, src_r[SRCW-1:SRCW-2]};
      trial_c = (RW+2)'({acc_r, 2'b01});
    end
    ge_c   = (sh_c >= trial_c);
    diff_c = sh_c - trial_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      div_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        div_r  <= ctl.op_div;
        cnt_r  <= ctl.op_div ? CW'(DIV_Q) : CW'(SO);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r <= '0;
      if (ctl.op_div) begin
        rem_r <= RW'(num >> DIV_Q);
        src_r <= SRCW'(num) << (SRCW - DIV_Q);
      end else begin
        rem_r <= '0;
        src_r <= SRCW'(radicand) << (SRCW - SQ_IN);
      end
    end else if (busy_r) begin
      rem_r <= ge_c ? RW'(diff_c) : RW'(sh_c);
      acc_r <= {acc_r[RES_W-2:0], ge_c};
      src_r <= div_r ? (src_r << 1) : (src_r << 2);
    end
  end

  assign result    = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* sv/fabrik_three_joint_ik_solver.sv */
// Three-joint FABRIK inverse-kinematics solver.
// Input channel in_*: one beat carries a target point (x, y, z, signed fixed point).
// Output channel out_*: one beat per target with the solved pose of the root,
// elbow and tip joints plus reached, out_of_reach and passes_used flags.
// Config port cfg_*: base point, pass limit and tolerance, to be written by the
// user only while idle; the block itself has no check for it. One target at a
// time: in_tready is high only while the block is idle. All square roots and
// divisions run on one shared digit-serial unit (one root digit or quotient
// bit per cycle) plus a squarer and one multiplier. Per target the solver
// finds three distances, then per pass four joint moves and one distance;
// out of reach it makes two joint moves after the distances and no pass.
// The result beat is held on out_* until out_tready; no new target is taken
// before it leaves. Reset restores the default pose root (0, 0.1, 0),
// elbow (-1, 1.5, 0), tip (1, 2.7, 0), base at the origin, ten passes and a
// tolerance of 655 LSB.
module fabrik_three_joint_ik_solver import fik_pkg::*; #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16,
  localparam int IN_W  = ((3 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((9 * COORD_BITS + 6 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // target_x, target_y, target_z
  input  logic [IN_W-1:0]       in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // root_x/y/z, elbow_x/y/z, tip_x/y/z, reached, out_of_reach, passes_used
  output logic [OUT_W-1:0]      out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_AW-1:0]     cfg_addr,
  input  logic [COORD_BITS-1:0] cfg_wdata
);

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int TW   = (C > 30) ? 30 : C;
  localparam int KMAX = C - TW;
  localparam int SQW  = 2 * TW + 2;
  localparam int SO   = TW + 1;
  localparam int LW   = C + 1;
  localparam int NW   = C + F;
  localparam int QW   = F + 1;
  localparam int PW   = QW + LW;
  localparam int RESW = C + 4;
  localparam int AW   = (SO > QW) ? SO : QW;

  typedef logic signed [C-1:0] crd_t;
  typedef logic signed [C:0]   dif_t;

  localparam longint ONE = longint'(1) <<< F;
  localparam crd_t RST_J0Y = C'(sat_coord((ONE + 5) / 10, C));
  localparam crd_t RST_J1X = C'(sat_coord(-ONE, C));
  localparam crd_t RST_J1Y = C'(sat_coord((3 * ONE) / 2, C));
  localparam crd_t RST_J2X = C'(sat_coord(ONE, C));
  localparam crd_t RST_J2Y = C'(sat_coord((27 * ONE + 5) / 10, C));
  localparam crd_t CMAX = {1'b0, {(C-1){1'b1}}};
  localparam crd_t CMIN = {1'b1, {(C-1){1'b0}}};

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_LOAD = 12'b000000000010,
    ST_SQ   = 12'b000000000100,
    ST_SGO  = 12'b000000001000,
    ST_ROOT = 12'b000000010000,
    ST_DGO  = 12'b000000100000,
    ST_DIV  = 12'b000001000000,
    ST_MUL  = 12'b000010000000,
    ST_ADD  = 12'b000100000000,
    ST_WB   = 12'b001000000000,
    ST_NEXT = 12'b010000000000,
    ST_OUT  = 12'b100000000000
  } state_t;

  state_t state_r;
  step_t  step_r;

  crd_t base_r [3];
  logic [ITER_W-1:0] max_iter_r;
  logic [TOL_W-1:0]  tol_r;

  crd_t j0_r [3];
  crd_t j1_r [3];
  crd_t j2_r [3];
  crd_t tgt_r [3];

  dif_t vec_r [3];
  crd_t org_r [3];
  crd_t new_r [3];
  logic [LW-1:0] seg_r;
  logic          clamp_r;
  logic [1:0]    ax_r;

  logic [LW-1:0] seg0_r;
  logic [LW-1:0] seg1_r;
  logic [LW-1:0] len_r;
  logic [SQW-1:0] sq_acc_r;
  logic [1:0]     k_r;
  logic [QW-1:0]  dir_r;
  logic [PW-1:0]  prod_r;

  logic              reached_r;
  logic              far_r;
  logic [ITER_W-1:0] passes_r;

  ar_ctl_t       ar_ctl;
  ar_stat_t      ar_stat;
  logic [AW-1:0] ar_res;

  logic [C-1:0]    mag_c [3];
  logic [C-1:0]    m_c;
  logic [1:0]      k_c;
  logic [TW-1:0]   t_c;
  logic [2*TW-1:0] sq_c;
  logic [LW-1:0]   len_c;
  logic [C+1:0]    sc_c;
  logic signed [RESW-1:0] off_c;
  logic signed [RESW-1:0] res_c;
  crd_t            sat_c;
  logic            is_dist_c;
  logic [LW:0]     seg_sum_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vec_r[i][C] ? C'(-vec_r[i]) : C'(vec_r[i]);
    end
    m_c = mag_c[0];
    if (mag_c[1] > m_c) m_c = mag_c[1];
    if (mag_c[2] > m_c) m_c = mag_c[2];
    // prescale wide differences so each square stays below 2^60
    k_c = 2'd0;
    for (int i = 1; i <= KMAX; i++) begin
      if ((m_c >> (29 + i)) != '0) k_c = 2'(i);
    end
    t_c   = TW'(mag_c[0] >> k_c);
    sq_c  = t_c * t_c;
    len_c = LW'(ar_res[SO-1:0]) << k_r;

    sc_c  = prod_r[PW-1:F];
    off_c = vec_r[0][C] ? -$signed({2'b00, sc_c}) : $signed({2'b00, sc_c});
    res_c = RESW'(org_r[0]) + off_c;
    if (clamp_r && ax_r == 2'd1 && res_c < RESW'(base_r[1])) res_c = RESW'(base_r[1]);
    if (res_c > RESW'(CMAX))      sat_c = CMAX;
    else if (res_c < RESW'(CMIN)) sat_c = CMIN;
    else                          sat_c = C'(res_c);

    is_dist_c = (step_r == STP_SEG0) || (step_r == STP_SEG1) ||
                (step_r == STP_FAR) || (step_r == STP_TOL);
    seg_sum_c = {1'b0, seg0_r} + {1'b0, seg1_r};

    ar_ctl.start  = (state_r == ST_SGO) || (state_r == ST_DGO && len_r != '0);
    ar_ctl.op_div = (state_r == ST_DGO);
  end

  fik_arith #(
    .SQ_IN  (SQW),
    .DIV_NUM(NW),
    .DIV_Q  (QW),
    .DEN_W  (LW),
    .RES_W  (AW)
  ) u_arith (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ar_ctl),
    .radicand(sq_acc_r),
    .num     (NW'(mag_c[0]) << F),
    .den     (len_r),
    .result  (ar_res),
    .stat    (ar_stat)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r[0]  <= '0;
      base_r[1]  <= '0;
      base_r[2]  <= '0;
      max_iter_r <= MAX_ITER_RST;
      tol_r      <= TOL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_BASE_X:    base_r[0]  <= cfg_wdata;
        CFG_BASE_Y:    base_r[1]  <= cfg_wdata;
        CFG_BASE_Z:    base_r[2]  <= cfg_wdata;
        CFG_MAX_ITER:  max_iter_r <= cfg_wdata[ITER_W-1:0];
        CFG_TOLERANCE: tol_r      <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and pose
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      step_r    <= STP_SEG0;
      j0_r[0] <= '0;      j0_r[1] <= RST_J0Y; j0_r[2] <= '0;
      j1_r[0] <= RST_J1X; j1_r[1] <= RST_J1Y; j1_r[2] <= '0;
      j2_r[0] <= RST_J2X; j2_r[1] <= RST_J2Y; j2_r[2] <= '0;
      reached_r <= 1'b0;
      far_r     <= 1'b0;
      passes_r  <= '0;
      ax_r      <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            for (int i = 0; i < 3; i++) tgt_r[i] <= in_tdata[i*C +: C];
            reached_r <= 1'b0;
            far_r     <= 1'b0;
            passes_r  <= '0;
            step_r    <= STP_SEG0;
            state_r   <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          ax_r     <= '0;
          sq_acc_r <= '0;
          clamp_r  <= (step_r != STP_FAR_J1) && (step_r != STP_FAR_J2);
          case (step_r)
            STP_SEG0:
              for (int i = 0; i < 3; i++) vec_r[i] <= dif_t'(j0_r[i]) - dif_t'(j1_r[i]);
            STP_SEG1:
              for (int i = 0; i < 3; i++) vec_r[i] <= dif_t'(j1_r[i]) - dif_t'(j2_r[i]);
            STP_FAR:
              for (int i = 0; i < 3; i++) vec_r[i] <= dif_t'(base_r[i]) - dif_t'(tgt_r[i]);
            STP_FAR_J1: begin
              for (int i = 0; i < 3; i++) begin
                vec_r[i] <= dif_t'(tgt_r[i]) - dif_t'(base_r[i]);
                org_r[i] <= base_r[i];
              end
              seg_r <= seg0_r;
            end
            STP_FAR_J2: begin
              for (int i = 0; i < 3; i++) begin
                vec_r[i] <= dif_t'(tgt_r[i]) - dif_t'(base_r[i]);
                org_r[i] <= j1_r[i];
              end
              seg_r <= seg1_r;
            end
            STP_F12: begin
              // tip snaps to the target, elbow follows it
              for (int i = 0; i < 3; i++) begin
                j2_r[i]  <= tgt_r[i];
                vec_r[i] <= dif_t'(j1_r[i]) - dif_t'(tgt_r[i]);
                org_r[i] <= tgt_r[i];
              end
              seg_r <= seg1_r;
            end
            STP_F01: begin
              for (int i = 0; i < 3; i++) begin
                vec_r[i] <= dif_t'(j0_r[i]) - dif_t'(j1_r[i]);
                org_r[i] <= j1_r[i];
              end
              seg_r <= seg0_r;
            end
            STP_B10: begin
              // root back to the base, elbow follows it
              for (int i = 0; i < 3; i++) begin
                j0_r[i]  <= base_r[i];
                vec_r[i] <= dif_t'(j1_r[i]) - dif_t'(base_r[i]);
                org_r[i] <= base_r[i];
              end
              seg_r <= seg0_r;
            end
            STP_B21: begin
              for (int i = 0; i < 3; i++) begin
                vec_r[i] <= dif_t'(j2_r[i]) - dif_t'(j1_r[i]);
                org_r[i] <= j1_r[i];
              end
              seg_r <= seg1_r;
            end
            default:
              for (int i = 0; i < 3; i++) vec_r[i] <= dif_t'(j2_r[i]) - dif_t'(tgt_r[i]);
          endcase
          state_r <= ST_SQ;
        end
        ST_SQ: begin
          sq_acc_r <= sq_acc_r + SQW'(sq_c);
          k_r      <= k_c;
          vec_r[0] <= vec_r[1];
          vec_r[1] <= vec_r[2];
          vec_r[2] <= vec_r[0];
          ax_r     <= (ax_r == 2'd2) ? 2'd0 : ax_r + 1'b1;
          if (ax_r == 2'd2) begin
            state_r <= ST_SGO;
          end
        end
        ST_SGO: begin
          state_r <= ST_ROOT;
        end
        ST_ROOT: begin
          if (ar_stat.done) begin
            len_r   <= len_c;
            state_r <= is_dist_c ? ST_NEXT : ST_DGO;
          end
        end
        ST_DGO: begin
          if (len_r != '0) begin
            state_r <= ST_DIV;
          end else begin
            dir_r   <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_DIV: begin
          if (ar_stat.done) begin
            dir_r   <= ar_res[QW-1:0];
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= dir_r * seg_r;
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          new_r[0] <= new_r[1];
          new_r[1] <= new_r[2];
          new_r[2] <= sat_c;
          vec_r[0] <= vec_r[1];
          vec_r[1] <= vec_r[2];
          vec_r[2] <= vec_r[0];
          org_r[0] <= org_r[1];
          org_r[1] <= org_r[2];
          org_r[2] <= org_r[0];
          ax_r     <= ax_r + 1'b1;
          state_r  <= (ax_r == 2'd2) ? ST_WB : ST_DGO;
        end
        ST_WB: begin
          case (step_r) inside
            STP_F01:                      for (int i = 0; i < 3; i++) j0_r[i] <= new_r[i];
            STP_FAR_J2, STP_B21:          for (int i = 0; i < 3; i++) j2_r[i] <= new_r[i];
            default:                      for (int i = 0; i < 3; i++) j1_r[i] <= new_r[i];
          endcase
          state_r <= ST_NEXT;
        end
        ST_NEXT: begin
          case (step_r)
            STP_SEG0: begin
              seg0_r  <= len_r;
              step_r  <= STP_SEG1;
              state_r <= ST_LOAD;
            end
            STP_SEG1: begin
              seg1_r  <= len_r;
              step_r  <= STP_FAR;
              state_r <= ST_LOAD;
            end
            STP_FAR: begin
              if ((LW+1)'(len_r) > seg_sum_c) begin
                far_r   <= 1'b1;
                step_r  <= STP_FAR_J1;
                state_r <= ST_LOAD;
              end else if (max_iter_r == '0) begin
                state_r <= ST_OUT;
              end else begin
                passes_r <= ITER_W'(1);
                step_r   <= STP_F12;
                state_r  <= ST_LOAD;
              end
            end
            STP_FAR_J1: begin
              step_r  <= STP_FAR_J2;
              state_r <= ST_LOAD;
            end
            STP_FAR_J2: state_r <= ST_OUT;
            STP_F12: begin
              step_r  <= STP_F01;
              state_r <= ST_LOAD;
            end
            STP_F01: begin
              step_r  <= STP_B10;
              state_r <= ST_LOAD;
            end
            STP_B10: begin
              step_r  <= STP_B21;
              state_r <= ST_LOAD;
            end
            STP_B21: begin
              step_r  <= STP_TOL;
              state_r <= ST_LOAD;
            end
            default: begin
              if (len_r < LW'(tol_r)) begin
                reached_r <= 1'b1;
                state_r   <= ST_OUT;
              end else if (passes_r == max_iter_r) begin
                state_r <= ST_OUT;
              end else begin
                passes_r <= passes_r + 1'b1;
                step_r   <= STP_F12;
                state_r  <= ST_LOAD;
              end
            end
          endcase
        end
        ST_OUT: begin
          if (out_tready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = OUT_W'({passes_r, far_r, reached_r,
                              j2_r[2], j2_r[1], j2_r[0],
                              j1_r[2], j1_r[1], j1_r[0],
                              j0_r[2], j0_r[1], j0_r[0]});

endmodule

/* sv/fik_checker.sv */
module fik_checker import fik_pkg::*; #(
  parameter int COORD_BITS = 24,
  localparam int OUT_W = ((9 * COORD_BITS + 6 + 7) / 8) * 8
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_W-1:0]      out_tdata
);

  localparam int FB = 9 * COORD_BITS;

  logic             reached;
  logic             far;
  logic [ITER_W-1:0] passes;

  assign reached = out_tdata[FB];
  assign far     = out_tdata[FB+1];
  assign passes  = out_tdata[FB+5:FB+2];

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("target accepted while a solve was running");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("ready for a target while a result is pending");

  a_far_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && far |-> passes == '0 && !reached)
    else $error("out-of-reach result with passes or reached set");

  a_reached_passes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && reached |-> passes != '0)
    else $error("reached without any pass");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

endmodule

bind fabrik_three_joint_ik_solver fik_checker #(.COORD_BITS(COORD_BITS)) u_fik_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
